// File: sv/shacal2_block_cipher_defines.svh
// Assertion macros shared by the cipher RTL.
// The implication forms take an antecedent and a consequent and are disabled in reset.
`ifndef SHACAL2_BLOCK_CIPHER_DEFINES_SVH
`define SHACAL2_BLOCK_CIPHER_DEFINES_SVH

`ifndef SYNTHESIS

`define SHACAL2_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define SHACAL2_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define SHACAL2_ASSERT_IMP(name, clk, rst_n, ante, cons, msg)

`define SHACAL2_ASSERT_NXT(name, clk, rst_n, ante, cons, msg)

`endif

`endif

// File: sv/shacal2_pkg.sv
package shacal2_pkg;

  localparam int unsigned ROUNDS_DEF  = 64;
  localparam int unsigned NUM_SUBKEYS = 64;
  localparam int unsigned SK_AW       = 6;
  localparam int unsigned KEY_WORDS   = 8;
  localparam int unsigned KEY_AW      = 3;
  localparam int unsigned CFG_IDX_W   = 4;
  localparam int unsigned WORD_W      = 64;
  localparam int unsigned SUB_W       = 32;
  localparam int unsigned WIN_LEN     = 16;
  localparam int unsigned BLK_WORDS   = 4;

  typedef logic [SUB_W-1:0]  sub_t;
  typedef logic [SK_AW-1:0]  sk_addr_t;
  typedef logic [WORD_W-1:0] word_t;
  typedef logic [1:0]        wcnt_t;
  // Working variables a..h sit at elements 0..7.
  typedef logic [7:0][SUB_W-1:0] blk_t;

  localparam wcnt_t LAST_WORD = wcnt_t'(BLK_WORDS - 1);

  // Read response of the subkey store toward the round engine.
  typedef struct packed {
    logic ready;
    sub_t word;
  } sub_rsp_t;

  typedef enum logic [1:0] {
    CS_LOAD,
    CS_ROUND,
    CS_HOLD
  } core_state_e;

  localparam sub_t ROUND_K [NUM_SUBKEYS] = '{
    32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
    32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
    32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
    32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
    32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
    32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
    32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
    32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
    32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
    32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
    32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
    32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
    32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
    32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
    32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
    32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
  };

  function automatic sub_t rotr(sub_t x, int unsigned n);
    return (x >> n) | (x << (SUB_W - n));
  endfunction

  function automatic sub_t big_sig0(sub_t x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic sub_t big_sig1(sub_t x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic sub_t sml_sig0(sub_t x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic sub_t sml_sig1(sub_t x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic sub_t choose(sub_t x, sub_t y, sub_t z);
    return (x & y) ^ (~x & z);
  endfunction

  function automatic sub_t major(sub_t x, sub_t y, sub_t z);
    return (x & y) ^ (x & z) ^ (y & z);
  endfunction

  // One forward compression round; kw is the round constant plus the subkey.
  function automatic blk_t enc_round(blk_t s, sub_t kw);
    sub_t t1;
    sub_t t2;
    blk_t r;
    t1   = s[7] + big_sig1(s[4]) + choose(s[4], s[5], s[6]) + kw;
    t2   = big_sig0(s[0]) + major(s[0], s[1], s[2]);
    r[7] = s[6];
    r[6] = s[5];
    r[5] = s[4];
    r[4] = s[3] + t1;
    r[3] = s[2];
    r[2] = s[1];
    r[1] = s[0];
    r[0] = t1 + t2;
    return r;
  endfunction

  // Exact inverse of enc_round for the same kw.
  function automatic blk_t dec_round(blk_t s, sub_t kw);
    sub_t t1;
    sub_t t2;
    blk_t r;
    r[0] = s[1];
    r[1] = s[2];
    r[2] = s[3];
    r[4] = s[5];
    r[5] = s[6];
    r[6] = s[7];
    t2   = big_sig0(r[0]) + major(r[0], r[1], r[2]);
    t1   = s[0] - t2;
    r[3] = s[4] - t1;
    r[7] = t1 - (big_sig1(r[4]) + choose(r[4], r[5], r[6]) + kw);
    return r;
  endfunction

endpackage

// File: sv/shacal2_key_sched.sv
`include "shacal2_block_cipher_defines.svh"

module shacal2_key_sched
  import shacal2_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  word_t                cfg_data_i,
  input  sk_addr_t             rd_addr_i,
  output sub_rsp_t             sub_rsp_o
);

  localparam sk_addr_t LAST_SK = sk_addr_t'(NUM_SUBKEYS - 1);

  word_t    key_q [KEY_WORDS];
  sub_t     win_q [WIN_LEN];
  sub_t     sub_mem [NUM_SUBKEYS];
  sub_t     rd_q;
  logic     busy_q, busy_d;
  sk_addr_t exp_cnt_q, exp_cnt_d;

  logic  cfg_hit;
  word_t key_sel;
  sub_t  key_half;
  sub_t  calc_w;
  sub_t  new_w;

  assign cfg_hit  = cfg_we_i && (cfg_idx_i < CFG_IDX_W'(KEY_WORDS));
  assign key_sel  = key_q[exp_cnt_q[KEY_AW:1]];
  assign key_half = exp_cnt_q[0] ? key_sel[SUB_W-1:0] : key_sel[WORD_W-1:SUB_W];
  assign calc_w   = sml_sig1(win_q[WIN_LEN-2]) + win_q[WIN_LEN-7]
                  + sml_sig0(win_q[1]) + win_q[0];
  assign new_w    = (exp_cnt_q < sk_addr_t'(WIN_LEN)) ? key_half : calc_w;

  always_comb begin
    busy_d    = busy_q;
    exp_cnt_d = exp_cnt_q;
    if (cfg_hit) begin
      busy_d    = 1'b1;
      exp_cnt_d = '0;
    end else if (busy_q) begin
      exp_cnt_d = exp_cnt_q + sk_addr_t'(1);
      if (exp_cnt_q == LAST_SK) begin
        busy_d = 1'b0;
      end
    end
  end

  // Reset starts a schedule pass so the store holds the all-zero key's subkeys.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b1;
      exp_cnt_q <= '0;
      for (int i = 0; i < KEY_WORDS; i++) begin
        key_q[i] <= '0;
      end
    end else begin
      busy_q    <= busy_d;
      exp_cnt_q <= exp_cnt_d;
      if (cfg_hit) begin
        key_q[cfg_idx_i[KEY_AW-1:0]] <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      for (int i = 0; i < WIN_LEN - 1; i++) begin
        win_q[i] <= win_q[i+1];
      end
      win_q[WIN_LEN-1] <= new_w;
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      sub_mem[exp_cnt_q] <= new_w;
    end
    rd_q <= sub_mem[rd_addr_i];
  end

  assign sub_rsp_o.ready = ~busy_q & ~cfg_we_i;
  assign sub_rsp_o.word  = rd_q;

  `SHACAL2_ASSERT_NXT(a_cfg_restart, clk_i, rst_ni, cfg_hit, busy_q && exp_cnt_q == '0, "key write did not restart the schedule")
  `SHACAL2_ASSERT_NXT(a_sched_done, clk_i, rst_ni, busy_q && !cfg_hit && exp_cnt_q == LAST_SK, !busy_q, "schedule pass did not end after the last subkey")
  `SHACAL2_ASSERT_NXT(a_idle_stays, clk_i, rst_ni, !busy_q && !cfg_hit, !busy_q && exp_cnt_q == '0, "schedule left idle without a key write")

endmodule

// File: sv/shacal2_round_core.sv
`include "shacal2_block_cipher_defines.svh"

module shacal2_round_core
  import shacal2_pkg::*;
#(
  parameter int unsigned ROUNDS = ROUNDS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  word_t    data_word_i,
  input  logic     decrypt_i,
  input  sub_rsp_t sub_rsp_i,
  output sk_addr_t rd_addr_o,
  input  logic     res_free_i,
  output logic     res_load_o,
  output blk_t     res_data_o
);

  localparam sk_addr_t LAST_RND = sk_addr_t'(ROUNDS - 1);

  core_state_e state_q, state_d;
  wcnt_t       wcnt_q, wcnt_d;
  sk_addr_t    rnd_q, rnd_d;
  logic        dec_q, dec_d;
  blk_t        wrk_q, wrk_d;

  logic       in_acc;
  sk_addr_t   cur_idx;
  sub_t       kw;
  logic [2:0] hi_sel;
  logic [2:0] lo_sel;

  assign in_acc  = in_valid_i & sub_rsp_i.ready & (state_q == CS_LOAD);
  assign cur_idx = dec_q ? (LAST_RND - rnd_q) : rnd_q;
  assign kw      = ROUND_K[cur_idx] + sub_rsp_i.word;
  assign hi_sel  = {wcnt_q, 1'b0};
  assign lo_sel  = {wcnt_q, 1'b1};

  always_comb begin
    state_d    = state_q;
    wcnt_d     = wcnt_q;
    rnd_d      = rnd_q;
    dec_d      = dec_q;
    wrk_d      = wrk_q;
    in_stall_o = 1'b1;
    res_load_o = 1'b0;
    rd_addr_o  = dec_q ? (cur_idx - sk_addr_t'(1)) : (cur_idx + sk_addr_t'(1));
    unique case (state_q)
      CS_LOAD: begin
        in_stall_o = ~sub_rsp_i.ready;
        rd_addr_o  = decrypt_i ? LAST_RND : '0;
        if (in_acc) begin
          wrk_d[hi_sel] = data_word_i[WORD_W-1:SUB_W];
          wrk_d[lo_sel] = data_word_i[SUB_W-1:0];
          wcnt_d        = wcnt_q + wcnt_t'(1);
          if (wcnt_q == LAST_WORD) begin
            dec_d   = decrypt_i;
            rnd_d   = '0;
            state_d = CS_ROUND;
          end
        end
      end
      CS_ROUND: begin
        wrk_d = dec_q ? dec_round(wrk_q, kw) : enc_round(wrk_q, kw);
        rnd_d = rnd_q + sk_addr_t'(1);
        if (rnd_q == LAST_RND) begin
          state_d = CS_HOLD;
        end
      end
      CS_HOLD: begin
        if (res_free_i) begin
          res_load_o = 1'b1;
          state_d    = CS_LOAD;
        end
      end
      default: begin
        state_d = CS_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_LOAD;
      wcnt_q  <= '0;
      rnd_q   <= '0;
      dec_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      wcnt_q  <= wcnt_d;
      rnd_q   <= rnd_d;
      dec_q   <= dec_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wrk_q <= wrk_d;
  end

  assign res_data_o = wrk_q;

  `SHACAL2_ASSERT_NXT(a_last_round, clk_i, rst_ni, state_q == CS_ROUND && rnd_q == LAST_RND, state_q == CS_HOLD, "rounds did not stop after the last round")
  `SHACAL2_ASSERT_NXT(a_block_start, clk_i, rst_ni, in_acc && wcnt_q == LAST_WORD, state_q == CS_ROUND && rnd_q == '0, "fourth word did not start the rounds")
  `SHACAL2_ASSERT_IMP(a_count_idle, clk_i, rst_ni, state_q != CS_LOAD, wcnt_q == '0, "word count not cleared while rounds run")

endmodule

// File: sv/shacal2_out_buf.sv
module shacal2_out_buf
  import shacal2_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  res_load_i,
  input  blk_t  res_data_i,
  output logic  res_free_o,
  output logic  out_valid_o,
  input  logic  out_stall_i,
  output word_t result_word_o,
  output logic  last_of_block_o
);

  word_t buf_q [BLK_WORDS];
  logic  vld_q;
  wcnt_t cnt_q;
  logic  xfer;

  assign xfer = vld_q & ~out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      cnt_q <= '0;
    end else if (res_load_i) begin
      vld_q <= 1'b1;
      cnt_q <= '0;
    end else if (xfer) begin
      cnt_q <= cnt_q + wcnt_t'(1);
      if (cnt_q == LAST_WORD) begin
        vld_q <= 1'b0;
      end
    end
  end

  // The head word is always element zero; each transfer shifts the rest down.
  always_ff @(posedge clk_i) begin
    if (res_load_i) begin
      for (int k = 0; k < BLK_WORDS; k++) begin
        buf_q[k] <= {res_data_i[2*k], res_data_i[2*k+1]};
      end
    end else if (xfer) begin
      for (int k = 0; k < BLK_WORDS - 1; k++) begin
        buf_q[k] <= buf_q[k+1];
      end
    end
  end

  assign res_free_o      = ~vld_q;
  assign out_valid_o     = vld_q;
  assign result_word_o   = buf_q[0];
  assign last_of_block_o = (cnt_q == LAST_WORD);

endmodule

// File: sv/shacal2_block_cipher.sv
// Channel  Direction  Handshake                Payload
// in       sink       in_valid_i / in_stall_o   data_word_i[63:0], decrypt_i
// out      source     out_valid_o / out_stall_i result_word_o[63:0], last_of_block_o
// cfg      sink       cfg_we_i (no wait)        cfg_idx_i[3:0], cfg_data_i[63:0]
//
// A block is four input transfers, the rounds, a handoff to the output buffer and four output
// transfers; the output transfers overlap with loading the next block. The pace is set by the
// one-round-per-cycle engine reading one subkey per cycle from the subkey memory.
// After reset, and after every write to a key register, the schedule rewrites all 64
// subkeys; the input channel is stalled during that pass.
// The output holds its word while stalled; a finished block waits in the round engine
// until the output buffer has drained the previous one.
module shacal2_block_cipher
  import shacal2_pkg::*;
#(
  parameter int unsigned ROUNDS = ROUNDS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Input word channel.
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [63:0]          data_word_i,
  input  logic                 decrypt_i,
  // Result word channel.
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [63:0]          result_word_o,
  output logic                 last_of_block_o,
  // Key register write port; indexes eight and above are ignored.
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [63:0]          cfg_data_i
);

  // Subkey memory read path: the round engine presents the address of the next round's
  // subkey in the cycle before, so the registered read data lines up with the round that uses it.
  sub_rsp_t sub_rsp;
  sk_addr_t rd_addr;

  // Handoff of a finished block from the working registers into the output buffer.
  logic res_free;
  logic res_load;
  blk_t res_data;

  // Key registers, the SHA-256 message schedule and the 64-entry subkey memory.
  shacal2_key_sched u_key_sched (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .rd_addr_i  (rd_addr),
    .sub_rsp_o  (sub_rsp)
  );

  // Block assembly and the compression rounds, forward for encryption and in reverse
  // round order for decryption.
  shacal2_round_core #(
    .ROUNDS (ROUNDS)
  ) u_round_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .data_word_i (data_word_i),
    .decrypt_i   (decrypt_i),
    .sub_rsp_i   (sub_rsp),
    .rd_addr_o   (rd_addr),
    .res_free_i  (res_free),
    .res_load_o  (res_load),
    .res_data_o  (res_data)
  );

  // Output register stage: four result words, the last one flagged, so the next
  // block can load while this one is still being taken.
  shacal2_out_buf u_out_buf (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .res_load_i      (res_load),
    .res_data_i      (res_data),
    .res_free_o      (res_free),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .result_word_o   (result_word_o),
    .last_of_block_o (last_of_block_o)
  );

endmodule

// File: dv/testbench.sv
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // The block runs 64 rounds per block by default; the predictor follows that count.
  localparam int unsigned CIPHER_ROUNDS = shacal2_pkg::ROUNDS_DEF;
  localparam int unsigned IDX_W = shacal2_pkg::CFG_IDX_W;

  // Index of the first key register and the count of key registers.
  localparam bit [IDX_W-1:0] KEY_IDX_FIRST = 0;
  localparam int unsigned KEY_REG_COUNT = 8;
  // Three indexes past the key registers, used to check that such writes are dropped.
  localparam bit [IDX_W-1:0] IDX_UNUSED_LOW = 8;
  localparam bit [IDX_W-1:0] IDX_UNUSED_HIGH = 15;
  localparam bit [IDX_W-1:0] IDX_UNUSED_MID = 9;

  // Operation carried by the decrypt field of the fourth word.
  localparam bit OP_ENCRYPT = 1'b0;
  localparam bit OP_DECRYPT = 1'b1;

  // Quiet time after the last result: long enough for a block's rounds and handoff, or for
  // the schedule pass after a key write, to cover anything still in flight.
  localparam int unsigned DRAIN_CYCLES = 100;
  // Run length limit, set well above the slowest correct run to leave a wide margin.
  localparam int unsigned CYCLE_LIMIT = 300000;
  // Length of the receiver hold-off that fills the block up and stalls its input.
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  localparam int unsigned BLOCKS_PER_PHASE = 27;

  // SHA-256 round constants.
  localparam bit [31:0] SHA256_K [64] = '{
    32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
    32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
    32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
    32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
    32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
    32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
    32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
    32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
    32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
    32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
    32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
    32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
    32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
    32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
    32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
    32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
  };

  // The scoreboard keeps its own copy of the key registers, the expanded subkeys and the
  // partly loaded block. Each accepted input word is folded into that copy; the fourth
  // word of a block runs the cipher and queues the four result words it must produce.
  class cipher_scoreboard;
    typedef struct {
      bit [63:0] word;
      bit        last;
    } result_t;

    bit [63:0]   key_regs [KEY_REG_COUNT];
    bit [31:0]   subkeys [64];
    bit [31:0]   block_words [8];
    int unsigned word_slot;
    result_t     due_results [$];
    int unsigned errors;

    function new();
      foreach (key_regs[i]) key_regs[i] = '0;
      foreach (block_words[i]) block_words[i] = '0;
      word_slot = 0;
      errors = 0;
      expand_schedule();
    endfunction

    function bit [31:0] rot_right(bit [31:0] x, int unsigned n);
      return (x >> n) | (x << (32 - n));
    endfunction

    function bit [31:0] ep0(bit [31:0] x);
      return rot_right(x, 2) ^ rot_right(x, 13) ^ rot_right(x, 22);
    endfunction

    function bit [31:0] ep1(bit [31:0] x);
      return rot_right(x, 6) ^ rot_right(x, 11) ^ rot_right(x, 25);
    endfunction

    function bit [31:0] gam0(bit [31:0] x);
      return rot_right(x, 7) ^ rot_right(x, 18) ^ (x >> 3);
    endfunction

    function bit [31:0] gam1(bit [31:0] x);
      return rot_right(x, 17) ^ rot_right(x, 19) ^ (x >> 10);
    endfunction

    function bit [31:0] pick(bit [31:0] x, bit [31:0] y, bit [31:0] z);
      return (x & y) ^ (~x & z);
    endfunction

    function bit [31:0] vote(bit [31:0] x, bit [31:0] y, bit [31:0] z);
      return (x & y) ^ (x & z) ^ (y & z);
    endfunction

    // SHA-256 message schedule over the 512-bit key.
    function void expand_schedule();
      for (int t = 0; t < KEY_REG_COUNT; t++) begin
        subkeys[2*t]   = key_regs[t][63:32];
        subkeys[2*t+1] = key_regs[t][31:0];
      end
      for (int t = 16; t < 64; t++) begin
        subkeys[t] = gam1(subkeys[t-2]) + subkeys[t-7] + gam0(subkeys[t-15]) +
                     subkeys[t-16];
      end
    endfunction

    function void write_key(bit [IDX_W-1:0] idx, bit [63:0] value);
      if (idx < KEY_REG_COUNT) begin
        key_regs[idx[2:0]] = value;
        expand_schedule();
      end
    endfunction

    function void encipher();
      bit [31:0] v [8];
      bit [31:0] t1;
      bit [31:0] t2;
      v = block_words;
      for (int t = 0; t < CIPHER_ROUNDS; t++) begin
        t1 = v[7] + ep1(v[4]) + pick(v[4], v[5], v[6]) + SHA256_K[t % 64] +
             subkeys[t % 64];
        t2 = ep0(v[0]) + vote(v[0], v[1], v[2]);
        v[7] = v[6];
        v[6] = v[5];
        v[5] = v[4];
        v[4] = v[3] + t1;
        v[3] = v[2];
        v[2] = v[1];
        v[1] = v[0];
        v[0] = t1 + t2;
      end
      block_words = v;
    endfunction

    // Undoes the rounds in reverse order: shift the words back, then recover the
    // two sums that the forward round mixed into a and e.
    function void decipher();
      bit [31:0] v [8];
      bit [31:0] t1;
      bit [31:0] t2;
      int unsigned r;
      v = block_words;
      for (int t = CIPHER_ROUNDS; t > 0; t--) begin
        r = (t - 1) % 64;
        t1 = v[0];
        v[0] = v[1];
        v[1] = v[2];
        v[2] = v[3];
        v[3] = v[4];
        v[4] = v[5];
        v[5] = v[6];
        v[6] = v[7];
        t2 = ep0(v[0]) + vote(v[0], v[1], v[2]);
        t1 = t1 - t2;
        v[3] = v[3] - t1;
        v[7] = t1 - (ep1(v[4]) + pick(v[4], v[5], v[6]) + SHA256_K[r] + subkeys[r]);
      end
      block_words = v;
    endfunction

    function void note_word(bit [63:0] word, bit op);
      result_t res;
      block_words[2*word_slot]   = word[63:32];
      block_words[2*word_slot+1] = word[31:0];
      if (word_slot != 3) begin
        word_slot++;
        return;
      end
      word_slot = 0;
      if (op == OP_DECRYPT) decipher();
      else encipher();
      for (int k = 0; k < 4; k++) begin
        res.word = {block_words[2*k], block_words[2*k+1]};
        res.last = (k == 3);
        due_results.push_back(res);
      end
    endfunction

    function void check_word(bit [63:0] word, bit last);
      result_t want;
      if (due_results.size() == 0) begin
        $display("%0t: unexpected result word %h last %b, none pending", $time, word, last);
        errors++;
        return;
      end
      want = due_results.pop_front();
      if (want.word !== word) begin
        $display("%0t: result_word mismatch, expected %h, actual %h", $time, want.word, word);
        errors++;
      end
      if (want.last !== last) begin
        $display("%0t: last_of_block mismatch, expected %b, actual %b", $time, want.last,
                 last);
        errors++;
      end
    endfunction

    function int unsigned pending_count();
      return due_results.size();
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_stall_o;
  logic [63:0]      data_word_i;
  logic             decrypt_i;
  logic             out_valid_o;
  logic             out_stall_i;
  logic [63:0]      result_word_o;
  logic             last_of_block_o;
  logic             cfg_we_i;
  logic [IDX_W-1:0] cfg_idx_i;
  logic [63:0]      cfg_data_i;

  cipher_scoreboard board;

  // Idle rates of the two sides in percent, changed between phases.
  int unsigned in_idle_pct;
  int unsigned out_stall_pct;
  // Remaining cycles of a forced receiver hold-off; counted down by the stall process.
  int unsigned hold_left;
  int unsigned cycle_count;

  shacal2_block_cipher u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .data_word_i    (data_word_i),
    .decrypt_i      (decrypt_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .result_word_o  (result_word_o),
    .last_of_block_o(last_of_block_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
  end

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Receiver side. The stall input changes only at the falling edge. A pending hold-off
  // overrides the random stalls so that results back up into the block.
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i = 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall_i = ($urandom_range(99) < out_stall_pct);
    end
  end

  // Every output transfer is checked against the oldest pending prediction. Sampling at
  // the rising edge sees the values from before the edge, so the order of processes in
  // this time step does not matter.
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      board.check_word(result_word_o, last_of_block_o);
    end
  end

  // Hard limit on the run length, so that a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count = cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: cycle limit reached, %0d results still pending", $time,
               board.pending_count());
      $display("testbench failed");
      $finish;
    end
  end

  // Offers one word and holds it until a transfer takes it. Idle cycles are put in front
  // of the word at the sender's current rate; valid stays high from word to word when no
  // idle cycle falls in between.
  task automatic send_word(input bit [63:0] word, input bit op);
    @(negedge clk_i);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    data_word_i = word;
    decrypt_i = op;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    board.note_word(word, op);
  endtask

  task automatic stop_sending();
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  // The write port has no handshake: the register takes the data at the next rising edge.
  task automatic write_key(input bit [IDX_W-1:0] idx, input bit [63:0] value);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    board.write_key(idx, value);
  endtask

  // Waits for every predicted result, then lets the block finish any schedule pass or
  // partial block before the caller changes the key.
  task automatic settle();
    while (board.pending_count() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Mostly uniform words, with the extremes, single set bits and single clear bits mixed in.
  function automatic bit [63:0] random_word();
    bit [63:0] w;
    case ($urandom_range(15))
      0: w = '0;
      1: w = '1;
      2: w = 64'h1 << $urandom_range(63);
      3: w = ~(64'h1 << $urandom_range(63));
      default: w = {$urandom, $urandom};
    endcase
    return w;
  endfunction

  task automatic send_block(input bit [63:0] w0, input bit [63:0] w1,
                            input bit [63:0] w2, input bit [63:0] w3,
                            input bit [3:0] ops);
    send_word(w0, ops[0]);
    send_word(w1, ops[1]);
    send_word(w2, ops[2]);
    send_word(w3, ops[3]);
  endtask

  // One phase of random traffic under a new random key. The decrypt field is random on
  // every word, so the first three words of a block also carry both values.
  task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                           input bit with_hold);
    settle();
    for (int i = 0; i < KEY_REG_COUNT; i++) begin
      write_key(IDX_W'(KEY_IDX_FIRST + i), random_word());
    end
    in_idle_pct = idle_pct;
    out_stall_pct = stall_pct;
    @(posedge clk_i);
    if (with_hold) hold_left = HOLD_OFF_CYCLES;
    for (int b = 0; b < BLOCKS_PER_PHASE; b++) begin
      send_block(random_word(), random_word(), random_word(), random_word(),
                 4'($urandom_range(15)));
    end
    stop_sending();
  endtask

  initial begin
    board = new();
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    data_word_i = '0;
    decrypt_i = 1'b0;
    out_stall_i = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    in_idle_pct = 0;
    out_stall_pct = 0;
    hold_left = 0;
    cycle_count = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part. The reset key is all zeros: encrypt a zero block, then decrypt an
    // all-ones block. The block waits out the schedule pass that follows reset.
    send_block('0, '0, '0, '0, {4{OP_ENCRYPT}});
    send_block('1, '1, '1, '1, {4{OP_DECRYPT}});
    stop_sending();

    // All-ones key. The decrypt flag on the first three words must be ignored; only the
    // fourth word picks the operation.
    settle();
    for (int i = 0; i < KEY_REG_COUNT; i++) write_key(IDX_W'(KEY_IDX_FIRST + i), '1);
    send_block('1, '1, '1, '1, {OP_ENCRYPT, OP_DECRYPT, OP_DECRYPT, OP_DECRYPT});
    send_block('0, '0, '0, '0, {OP_DECRYPT, OP_ENCRYPT, OP_ENCRYPT, OP_ENCRYPT});
    stop_sending();

    // Writes past the last key register must leave the key alone.
    settle();
    write_key(KEY_IDX_FIRST, 64'h8000_0000_0000_0001);
    write_key(IDX_UNUSED_LOW, random_word());
    write_key(IDX_UNUSED_HIGH, '1);
    send_block(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
               64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001, {4{OP_ENCRYPT}});

    // Key change in the middle of a block: the block must use the key present when its
    // fourth word arrives.
    send_word(random_word(), OP_DECRYPT);
    send_word(random_word(), OP_ENCRYPT);
    stop_sending();
    settle();
    write_key(IDX_W'(KEY_IDX_FIRST + 5), random_word());
    write_key(IDX_UNUSED_MID, random_word());
    send_word(random_word(), OP_ENCRYPT);
    send_word(random_word(), OP_DECRYPT);
    stop_sending();

    // Random phases: no idling, a slow sender, a slow receiver, then both lightly with
    // a long receiver hold-off at the start so the block fills and stalls its input.
    run_phase(0, 0, 1'b0);
    run_phase(45, 0, 1'b0);
    run_phase(0, 45, 1'b0);
    run_phase(11, 11, 1'b1);

    settle();
    if (board.pending_count() != 0) begin
      $display("%0t: %0d predicted results never arrived", $time, board.pending_count());
    end
    if (board.errors == 0 && board.pending_count() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: files.f
+incdir+sv
sv/shacal2_pkg.sv
sv/shacal2_key_sched.sv
sv/shacal2_round_core.sv
sv/shacal2_out_buf.sv
sv/shacal2_block_cipher.sv
dv/testbench.sv
